>>> rtl/lsmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsmt_pkg
// Shared types and constants for the LCD scanline and mode timer.
// ----------------------------------------------------------------------------
package lsmt_pkg;

    // dots per scanline and mode boundaries
    localparam logic [9:0] LINE_DOTS   = 10'd456;
    localparam logic [8:0] MODE2_END   = 9'd80;
    localparam logic [8:0] MODE3_END   = 9'd252;
    localparam logic [7:0] VBLANK_LINE = 8'd144;
    localparam logic [7:0] LAST_LINE   = 8'd153;

    // lcd mode codes
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_HBLANK   = 2'd0;
    localparam mode_t MODE_VBLANK   = 2'd1;
    localparam mode_t MODE_OAM      = 2'd2;
    localparam mode_t MODE_TRANSFER = 2'd3;

    // status interrupt enable bit positions
    localparam int unsigned EN_HBLANK = 0;
    localparam int unsigned EN_VBLANK = 1;
    localparam int unsigned EN_OAM    = 2;
    localparam int unsigned EN_COIN   = 3;

    // configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_DISPLAY_ON   = 2'd0;
    localparam cfg_index_t REG_LINE_COMPARE = 2'd1;
    localparam cfg_index_t REG_STAT_ENABLES = 2'd2;

    localparam int unsigned CFG_DATA_W = 8;

    typedef struct packed {
        logic       display_on;
        logic [7:0] line_compare;
        logic [3:0] stat_int_enables;
    } cfg_t;

    typedef struct packed {
        logic [7:0] current_line;
        mode_t      lcd_mode;
        logic       coincidence;
        logic       stat_irq;
        logic       vblank_irq;
    } result_t;

endpackage
`default_nettype wire

>>> rtl/lsmt_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsmt_cfg_regs
// Configuration register file, write only, one register per index.
// ----------------------------------------------------------------------------
module lsmt_cfg_regs (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire lsmt_pkg::cfg_index_t                  cfg_index,
    input  wire logic [lsmt_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    output lsmt_pkg::cfg_t                             cfg
);

    lsmt_pkg::cfg_t cfg_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lsmt_pkg::REG_DISPLAY_ON:   cfg_reg.display_on       <= cfg_wr_data[0];
                lsmt_pkg::REG_LINE_COMPARE: cfg_reg.line_compare     <= cfg_wr_data[7:0];
                lsmt_pkg::REG_STAT_ENABLES: cfg_reg.stat_int_enables <= cfg_wr_data[3:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

>>> rtl/lsmt_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsmt_in_stage
// Input register holding one cycles word until the core takes it.
// ----------------------------------------------------------------------------
module lsmt_in_stage (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_cycles,
    input  wire logic       take,
    output logic            word_valid,
    output logic [7:0]      word_cycles
);

    logic       valid_reg;
    logic [7:0] cycles_reg;

    // room when empty or when the held word leaves this cycle
    assign s_ready = !valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cycles_reg <= s_cycles;
        end
    end

    assign word_valid  = valid_reg;
    assign word_cycles = cycles_reg;

endmodule
`default_nettype wire

>>> rtl/lsmt_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsmt_core
// Mode derivation, interrupt logic and dot/line advance with timing state.
// ----------------------------------------------------------------------------
module lsmt_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            fire,
    input  wire logic [7:0]      cycles,
    input  wire lsmt_pkg::cfg_t  cfg,
    output lsmt_pkg::result_t    result
);

    logic [8:0]      dot_reg,  dot_next;
    logic [7:0]      line_reg, line_next;
    lsmt_pkg::mode_t prev_mode_reg, prev_mode_next;

    lsmt_pkg::mode_t mode;
    logic            mode_en;
    logic            coin;
    logic            sirq;
    logic            virq;
    logic [9:0]      dot_sum;
    logic            wrap;
    logic [9:0]      dot_wrapped;

    // mode from the stored counter and line
    always_comb begin
        if (line_reg >= lsmt_pkg::VBLANK_LINE) begin
            mode = lsmt_pkg::MODE_VBLANK;
        end else if (dot_reg <= lsmt_pkg::MODE2_END) begin
            mode = lsmt_pkg::MODE_OAM;
        end else if (dot_reg <= lsmt_pkg::MODE3_END) begin
            mode = lsmt_pkg::MODE_TRANSFER;
        end else begin
            mode = lsmt_pkg::MODE_HBLANK;
        end
    end

    // per-mode status enable, transfer has none
    always_comb begin
        case (mode)
            lsmt_pkg::MODE_HBLANK: mode_en = cfg.stat_int_enables[lsmt_pkg::EN_HBLANK];
            lsmt_pkg::MODE_VBLANK: mode_en = cfg.stat_int_enables[lsmt_pkg::EN_VBLANK];
            lsmt_pkg::MODE_OAM:    mode_en = cfg.stat_int_enables[lsmt_pkg::EN_OAM];
            default:               mode_en = 1'b0;
        endcase
    end

    assign coin = (line_reg == cfg.line_compare);
    assign sirq = ((mode != prev_mode_reg) && mode_en)
                || (coin && cfg.stat_int_enables[lsmt_pkg::EN_COIN]);

    // dot advance, at most one line wrap per word
    assign dot_sum     = {1'b0, dot_reg} + {2'b00, cycles};
    assign wrap        = (dot_sum >= lsmt_pkg::LINE_DOTS);
    assign dot_wrapped = wrap ? (dot_sum - lsmt_pkg::LINE_DOTS) : dot_sum;

    always_comb begin
        dot_next       = dot_reg;
        line_next      = line_reg;
        prev_mode_next = prev_mode_reg;
        virq           = 1'b0;
        if (!cfg.display_on) begin
            dot_next       = '0;
            line_next      = '0;
            prev_mode_next = lsmt_pkg::MODE_VBLANK;
        end else begin
            prev_mode_next = mode;
            dot_next       = dot_wrapped[8:0];
            if (wrap) begin
                if (line_reg >= lsmt_pkg::LAST_LINE) begin
                    line_next = '0;
                end else begin
                    line_next = line_reg + 8'd1;
                end
                virq = (line_next == lsmt_pkg::VBLANK_LINE);
            end
        end
    end

    // timing state, updated once per word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg       <= '0;
            line_reg      <= '0;
            prev_mode_reg <= lsmt_pkg::MODE_HBLANK;
        end else if (fire) begin
            dot_reg       <= dot_next;
            line_reg      <= line_next;
            prev_mode_reg <= prev_mode_next;
        end
    end

    // result word, display off reports vblank at line zero
    always_comb begin
        if (!cfg.display_on) begin
            result.current_line = '0;
            result.lcd_mode     = lsmt_pkg::MODE_VBLANK;
            result.coincidence  = (cfg.line_compare == 8'd0);
            result.stat_irq     = 1'b0;
            result.vblank_irq   = 1'b0;
        end else begin
            result.current_line = line_next;
            result.lcd_mode     = mode;
            result.coincidence  = coin;
            result.stat_irq     = sirq;
            result.vblank_irq   = virq;
        end
    end

endmodule
`default_nettype wire

>>> rtl/lsmt_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsmt_out_stage
// Result register feeding the output channel.
// ----------------------------------------------------------------------------
module lsmt_out_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire lsmt_pkg::result_t  result,
    output logic                    room,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output lsmt_pkg::result_t       m_result
);

    logic              valid_reg;
    lsmt_pkg::result_t result_reg;

    // free when empty or when the held word is taken this cycle
    assign room = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (room) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule
`default_nettype wire

>>> rtl/lcd_scanline_mode_timer_unit.sv
`default_nettype none
// Path: an accepted word waits in the input register, then moves to the result register.
// Throughput: one word per cycle while the output is not stalled, set by the single dot
// add, wrap compare and line step between the input register and the result register.
// Reset: synchronous, active low; clears timing state, configuration and
// both stage valid flags.
// ----------------------------------------------------------------------------
// lcd_scanline_mode_timer_unit
// Scanline dot counter, LCD mode derivation and status/vblank interrupts.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_timer_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [lsmt_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_cycles,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [7:0]                             m_current_line,
    output logic [1:0]                             m_lcd_mode,
    output logic                                   m_coincidence,
    output logic                                   m_stat_irq,
    output logic                                   m_vblank_irq
);

    lsmt_pkg::cfg_t    cfg;
    lsmt_pkg::result_t core_result;
    lsmt_pkg::result_t out_result;
    logic              word_valid;
    logic [7:0]        word_cycles;
    logic              room;
    logic              fire;

    // a held word moves on when the result register has room
    assign fire = word_valid && room;

    lsmt_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    lsmt_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cycles    (s_cycles),
        .take        (fire),
        .word_valid  (word_valid),
        .word_cycles (word_cycles)
    );

    lsmt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .cycles  (word_cycles),
        .cfg     (cfg),
        .result  (core_result)
    );

    lsmt_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result   (core_result),
        .room     (room),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (out_result)
    );

    assign m_current_line = out_result.current_line;
    assign m_lcd_mode     = out_result.lcd_mode;
    assign m_coincidence  = out_result.coincidence;
    assign m_stat_irq     = out_result.stat_irq;
    assign m_vblank_irq   = out_result.vblank_irq;

    // vblank pulse only ever reports line 144
    a_vblank_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_vblank_irq) |-> (m_current_line == lsmt_pkg::VBLANK_LINE))
        else $error("vblank pulse away from line 144");

    // reported line stays inside the frame
    a_line_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_current_line <= lsmt_pkg::LAST_LINE))
        else $error("line beyond last scanline");

    // pixel transfer is seen on a visible line, so the advance reaches line 144 at most
    a_transfer_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_lcd_mode == lsmt_pkg::MODE_TRANSFER))
            |-> (m_current_line <= lsmt_pkg::VBLANK_LINE))
        else $error("transfer mode past vblank entry");

    // a word moved into the result register shows as valid next cycle
    a_fire_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid)
        else $error("result lost after transfer");

endmodule
`default_nettype wire
